FILE: hw/rtl/http_request_header_tokenizer_macros.svh
// Assertion macros for the HTTP request header tokenizer.
// Self-contained; included by the RTL files that carry assertions.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define HTOK_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Condition a implies condition b in the next cycle.
`define HTOK_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

FILE: hw/rtl/htok_pkg.sv
// Shared types and constants of the HTTP request header tokenizer.
// No dependencies; used by htok_step and the top level.
`default_nettype none

package htok_pkg;

   // Parse phases of the request.
   typedef enum logic [3:0] {
      PH_METHOD_FIRST = 4'd0,
      PH_METHOD       = 4'd1,
      PH_URL_FIRST    = 4'd2,
      PH_URL          = 4'd3,
      PH_VER_FIRST    = 4'd4,
      PH_VER          = 4'd5,
      PH_LINE_START   = 4'd6,
      PH_NAME         = 4'd7,
      PH_SKIP         = 4'd8,
      PH_VALUE        = 4'd9,
      PH_BODY_FIRST   = 4'd10,
      PH_BODY         = 4'd11,
      PH_FAILED       = 4'd12
   } phase_type;

   // Field kinds of a tagged byte.
   localparam logic [2:0] KIND_DELIM   = 3'd0;
   localparam logic [2:0] KIND_METHOD  = 3'd1;
   localparam logic [2:0] KIND_PATH    = 3'd2;
   localparam logic [2:0] KIND_QUERY   = 3'd3;
   localparam logic [2:0] KIND_VERSION = 3'd4;
   localparam logic [2:0] KIND_NAME    = 3'd5;
   localparam logic [2:0] KIND_VALUE   = 3'd6;
   localparam logic [2:0] KIND_BODY    = 3'd7;

   // Parse verdicts.
   localparam logic [1:0] STATUS_PARSING   = 2'd0;
   localparam logic [1:0] STATUS_ACCEPTED  = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   // Delimiter characters.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // The only accepted protocol version, one character per position.
   localparam int VERSION_LEN = 8;
   localparam logic [7:0] VERSION_TEXT [VERSION_LEN] = '{
      8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31
   };

   // Parser state carried from one byte to the next.
   typedef struct packed {
      phase_type  phase;
      logic [3:0] ver_idx;
      logic       ver_mismatch;
      logic       query_seen;
      logic       pending_cr;
      logic [1:0] final_status;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_METHOD_FIRST,
      ver_idx:      4'd0,
      ver_mismatch: 1'b0,
      query_seen:   1'b0,
      pending_cr:   1'b0,
      final_status: STATUS_PARSING
   };

   // Tag attached to one byte.
   typedef struct packed {
      logic [2:0] kind;
      logic       start;
      logic [1:0] status;
   } tag_type;

endpackage

`default_nettype wire

FILE: hw/rtl/http_request_header_tokenizer.sv
// Top level of the HTTP request header tokenizer; depends on htok_pkg, htok_step and the macros.
// A request accepted at a clock edge is held in the input register, then loaded into the result
// register that drives rsp_*; while the result is stalled, it waits in the input register.
// Throughput: one byte per cycle unless rsp_ready stalls the result; the input register refills
// in the same cycle the output register is loaded, so the parse state updates once per byte.
// Reset (synchronous, active high) empties both registers and restarts the parser.
`default_nettype none
`include "http_request_header_tokenizer_macros.svh"

module http_request_header_tokenizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_buffer,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [2:0]      rsp_field_kind,
   output logic            rsp_field_start,
   output logic [1:0]      rsp_parse_status
);

   // Input register.
   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;

   // Parser state and output register.
   htok_pkg::state_type state_ff;
   htok_pkg::state_type state_in;
   htok_pkg::tag_type   tag_in;
   htok_pkg::tag_type   out_tag_ff;
   logic [7:0]          out_byte_ff;
   logic                out_valid_ff;

   logic                out_free;
   logic                advance;

   // Handshake: a byte moves on when the output register is empty or being drained.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   htok_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (state_in),
      .tag       (tag_in)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_end_of_buffer;
      end
   end

   // Parser state and result register advance together.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htok_pkg::STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         out_byte_ff <= in_byte_ff;
         out_tag_ff  <= tag_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_field_kind   = out_tag_ff.kind;
   assign rsp_field_start  = out_tag_ff.start;
   assign rsp_parse_status = out_tag_ff.status;

   // Consistency checks.
   `HTOK_ASSERT_IMPLY(a_delim_no_start, clock, reset,
      rsp_valid && rsp_field_kind == htok_pkg::KIND_DELIM, !rsp_field_start,
      "delimiter byte flagged as field start")
   `HTOK_ASSERT_IMPLY(a_failed_status, clock, reset,
      state_ff.phase == htok_pkg::PH_FAILED,
      state_ff.final_status == htok_pkg::STATUS_MALFORMED && !state_ff.pending_cr,
      "failed phase without malformed verdict")
   `HTOK_ASSERT_IMPLY(a_body_status, clock, reset,
      state_ff.phase == htok_pkg::PH_BODY_FIRST || state_ff.phase == htok_pkg::PH_BODY,
      state_ff.final_status == htok_pkg::STATUS_ACCEPTED,
      "body phase without accepted verdict")
   `HTOK_ASSERT_IMPLY(a_cr_phase, clock, reset, state_ff.pending_cr,
      state_ff.phase == htok_pkg::PH_VER_FIRST || state_ff.phase == htok_pkg::PH_VER ||
      state_ff.phase == htok_pkg::PH_LINE_START || state_ff.phase == htok_pkg::PH_SKIP ||
      state_ff.phase == htok_pkg::PH_VALUE,
      "pending CR in a phase that cannot end a line")
   `HTOK_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(state_ff),
      "parser state moved while the result was stalled")

endmodule

`default_nettype wire

FILE: hw/rtl/htok_step.sv
// One parse step: tags a byte and computes the parser state after it.
// Depends on htok_pkg.
`default_nettype none

module htok_step (
   input  wire htok_pkg::state_type cur_state,
   input  wire logic [7:0]          data_byte,
   input  wire logic                last_byte,
   output htok_pkg::state_type      nxt_state,
   output htok_pkg::tag_type        tag
);

   htok_pkg::state_type st;
   logic [2:0]          kind;
   logic                start;
   logic [1:0]          status;

   always_comb begin
      st    = cur_state;
      kind  = htok_pkg::KIND_DELIM;
      start = 1'b0;

      if (cur_state.pending_cr) begin
         // A CR ended a line; only LF may follow.
         st.pending_cr = 1'b0;
         if (data_byte != htok_pkg::CHAR_LF) begin
            st.phase        = htok_pkg::PH_FAILED;
            st.final_status = htok_pkg::STATUS_MALFORMED;
         end else if (cur_state.phase == htok_pkg::PH_VER_FIRST ||
                      cur_state.phase == htok_pkg::PH_VER) begin
            if (cur_state.ver_idx == 4'(htok_pkg::VERSION_LEN) && !cur_state.ver_mismatch) begin
               st.phase = htok_pkg::PH_LINE_START;
            end else begin
               st.phase        = htok_pkg::PH_FAILED;
               st.final_status = htok_pkg::STATUS_MALFORMED;
            end
         end else if (cur_state.phase == htok_pkg::PH_LINE_START) begin
            st.phase        = htok_pkg::PH_BODY_FIRST;
            st.final_status = htok_pkg::STATUS_ACCEPTED;
         end else begin
            st.phase = htok_pkg::PH_LINE_START;
         end
      end else begin
         unique case (cur_state.phase) inside
            htok_pkg::PH_METHOD_FIRST, htok_pkg::PH_METHOD: begin
               if (data_byte == htok_pkg::CHAR_SPACE) begin
                  st.phase = htok_pkg::PH_URL_FIRST;
               end else begin
                  kind     = htok_pkg::KIND_METHOD;
                  start    = (cur_state.phase == htok_pkg::PH_METHOD_FIRST);
                  st.phase = htok_pkg::PH_METHOD;
               end
            end
            htok_pkg::PH_URL_FIRST, htok_pkg::PH_URL: begin
               if (data_byte == htok_pkg::CHAR_SPACE) begin
                  st.phase = htok_pkg::PH_VER_FIRST;
               end else if (data_byte == htok_pkg::CHAR_QMARK && !cur_state.query_seen) begin
                  st.query_seen = 1'b1;
                  st.phase      = htok_pkg::PH_URL_FIRST;
               end else begin
                  kind     = cur_state.query_seen ? htok_pkg::KIND_QUERY : htok_pkg::KIND_PATH;
                  start    = (cur_state.phase == htok_pkg::PH_URL_FIRST);
                  st.phase = htok_pkg::PH_URL;
               end
            end
            htok_pkg::PH_VER_FIRST, htok_pkg::PH_VER: begin
               if (data_byte == htok_pkg::CHAR_CR) begin
                  st.pending_cr = 1'b1;
               end else begin
                  kind     = htok_pkg::KIND_VERSION;
                  start    = (cur_state.phase == htok_pkg::PH_VER_FIRST);
                  st.phase = htok_pkg::PH_VER;
                  // The index saturates at the text length; any extra byte is a mismatch.
                  if (cur_state.ver_idx[3]) begin
                     st.ver_mismatch = 1'b1;
                  end else begin
                     if (htok_pkg::VERSION_TEXT[cur_state.ver_idx[2:0]] != data_byte) begin
                        st.ver_mismatch = 1'b1;
                     end
                     st.ver_idx = cur_state.ver_idx + 4'd1;
                  end
               end
            end
            htok_pkg::PH_LINE_START: begin
               if (data_byte == htok_pkg::CHAR_CR) begin
                  st.pending_cr = 1'b1;
               end else if (data_byte == htok_pkg::CHAR_COLON) begin
                  st.phase = htok_pkg::PH_SKIP;
               end else begin
                  kind     = htok_pkg::KIND_NAME;
                  start    = 1'b1;
                  st.phase = htok_pkg::PH_NAME;
               end
            end
            htok_pkg::PH_NAME: begin
               // A CR inside a name means a header line without a colon.
               if (data_byte == htok_pkg::CHAR_COLON) begin
                  st.phase = htok_pkg::PH_SKIP;
               end else if (data_byte == htok_pkg::CHAR_CR) begin
                  st.phase        = htok_pkg::PH_FAILED;
                  st.final_status = htok_pkg::STATUS_MALFORMED;
               end else begin
                  kind = htok_pkg::KIND_NAME;
               end
            end
            htok_pkg::PH_SKIP: begin
               if (data_byte == htok_pkg::CHAR_SPACE) begin
                  st.phase = htok_pkg::PH_SKIP;
               end else if (data_byte == htok_pkg::CHAR_CR) begin
                  st.pending_cr = 1'b1;
               end else begin
                  kind     = htok_pkg::KIND_VALUE;
                  start    = 1'b1;
                  st.phase = htok_pkg::PH_VALUE;
               end
            end
            htok_pkg::PH_VALUE: begin
               if (data_byte == htok_pkg::CHAR_CR) begin
                  st.pending_cr = 1'b1;
               end else begin
                  kind = htok_pkg::KIND_VALUE;
               end
            end
            htok_pkg::PH_BODY_FIRST: begin
               kind     = htok_pkg::KIND_BODY;
               start    = 1'b1;
               st.phase = htok_pkg::PH_BODY;
            end
            htok_pkg::PH_BODY: begin
               kind = htok_pkg::KIND_BODY;
            end
            default: begin
               st.phase        = htok_pkg::PH_FAILED;
               st.final_status = htok_pkg::STATUS_MALFORMED;
               st.pending_cr   = 1'b0;
            end
         endcase
      end

      // At the end of the buffer an open request is judged, then the parser restarts.
      status = st.final_status;
      if (last_byte) begin
         if (status == htok_pkg::STATUS_PARSING) begin
            status = (st.phase == htok_pkg::PH_LINE_START && !st.pending_cr) ?
                     htok_pkg::STATUS_ACCEPTED : htok_pkg::STATUS_MALFORMED;
         end
         st = htok_pkg::STATE_RESET;
      end
   end

   assign nxt_state  = st;
   assign tag.kind   = kind;
   assign tag.start  = start;
   assign tag.status = status;

endmodule

`default_nettype wire
